/* hdl/uvx_pkg.sv */
// Shared types, constants and helper functions for the URL tag value extractor.
package uvx_pkg;

  localparam int MAX_VALUE_BUF = 32;
  localparam int BUF_AW        = $clog2(MAX_VALUE_BUF);
  localparam int LEN_W         = $clog2(MAX_VALUE_BUF + 2);
  localparam int NUM_KEYS      = 3;
  localparam int KEY_MAX_LEN   = 13;
  localparam int POS_W         = 4;
  localparam int CFG_W         = 6;
  localparam int CMDQ_DEPTH    = 2;
  localparam int OUTQ_DEPTH    = 2;

  localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(32);
  localparam logic [LEN_W-1:0] RUN_LEN_SAT   = LEN_W'(MAX_VALUE_BUF + 1);

  localparam logic [1:0] KEY_MEDIUM   = 2'd0;
  localparam logic [1:0] KEY_SOURCE   = 2'd1;
  localparam logic [1:0] KEY_CAMPAIGN = 2'd2;
  localparam logic [1:0] KEY_MARK     = 2'd3;

  localparam logic [8*KEY_MAX_LEN-1:0] KEY_STR [NUM_KEYS] = '{
    {16'h0000, "utm_", "medium="}, {16'h0000, "utm_", "source="}, {"utm_", "campaign="}
  };
  localparam logic [POS_W-1:0] KEY_LEN [NUM_KEYS] = '{4'd11, 4'd11, 4'd13};

  typedef logic [1:0]       key_id_t;
  typedef logic [LEN_W-1:0] run_len_t;

  typedef struct packed {
    logic     emit;
    logic     mark;
    key_id_t  key;
    run_len_t len;
    logic     bank;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [BUF_AW:0]   addr;
    logic [7:0]        data;
  } buf_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  function automatic logic [7:0] key_char(input int k, input logic [POS_W-1:0] i);
    int sh;
    sh = 8 * (int'(KEY_LEN[k]) - 1 - int'(i));
    if (sh < 0) return 8'h00;
    return KEY_STR[k][sh +: 8];
  endfunction

  // Longest key prefix that ends with the new byte. The two-byte start of every
  // key occurs only at its head, so at most a fallback to one or two bytes exists.
  function automatic logic [POS_W-1:0] next_match(input int k, input logic [POS_W-1:0] pos,
                                                  input logic [7:0] c);
    if (c == key_char(k, pos)) return pos + 1'b1;
    if (pos >= POS_W'(2) && c == key_char(k, POS_W'(1)) &&
        key_char(k, pos - 1'b1) == key_char(k, POS_W'(0))) return POS_W'(2);
    if (c == key_char(k, POS_W'(0))) return POS_W'(1);
    return '0;
  endfunction

  function automatic logic is_value_byte(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == "_" || c == "-" || c == "." || c == " ";
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

endpackage

/* hdl/uvx_cmd_fifo.sv */
// Two-entry command queue between the front and back parts.
module uvx_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  uvx_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd,
  output uvx_pkg::cmd_t rd_cmd,
  output logic          empty
);
  import uvx_pkg::*;

  localparam int AW = $clog2(CMDQ_DEPTH);

  cmd_t          slots [CMDQ_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full   = (count == (AW + 1)'(CMDQ_DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr && !full) begin
        slots[wr_ptr] <= wr_cmd;
        wr_ptr        <= (wr_ptr == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd && !empty) begin
        rd_ptr <= (rd_ptr == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW + 1)'(wr && !full) - (AW + 1)'(rd && !empty);
    end
  end

endmodule

/* hdl/uvx_front.sv */
// Front part: key matching, run capture into the buffer banks and command issue.
module uvx_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        char_in,
  input  logic                              end_of_string,
  input  logic                              cfg_we,
  input  logic [uvx_pkg::CFG_W-1:0]         cfg_wdata,
  output uvx_pkg::cmd_t                     cmd,
  output logic                              cmd_push,
  input  logic                              cmd_full,
  output uvx_pkg::buf_wr_t                  buf_wr,
  input  uvx_pkg::bank_rel_t                bank_rel,
  output logic [1:0]                        bank_busy
);
  import uvx_pkg::*;

  logic [CFG_W-1:0] max_value_len;
  logic [POS_W-1:0] match_pos [NUM_KEYS];
  logic [NUM_KEYS-1:0] key_found;
  logic             capturing;
  key_id_t          capture_key;
  run_len_t         capture_length;
  logic             bank;

  logic [POS_W-1:0]    pos_next [NUM_KEYS];
  logic [POS_W-1:0]    np [NUM_KEYS];
  logic [NUM_KEYS-1:0] found_next;
  logic                capturing_next;
  key_id_t             capture_key_next;
  run_len_t            capture_length_next;
  logic [1:0]          bank_busy_next;
  logic                accept;
  logic                valid_c;
  logic                emit_end;
  logic                emit_eos;

  function automatic logic run_fits(input run_len_t len, input logic [CFG_W-1:0] lim);
    return len != '0 && int'(len) <= int'(lim) && int'(len) <= MAX_VALUE_BUF;
  endfunction

  assign full   = cmd_full || bank_busy[bank];
  assign accept = push && !full;

  always_comb begin
    valid_c             = is_value_byte(char_in);
    capturing_next      = capturing;
    capture_key_next    = capture_key;
    capture_length_next = capture_length;
    emit_end            = 1'b0;
    if (capturing && valid_c) begin
      if (capture_length < RUN_LEN_SAT) capture_length_next = capture_length + 1'b1;
    end
    if (capturing && !valid_c) begin
      emit_end            = run_fits(capture_length, max_value_len);
      capturing_next      = 1'b0;
      capture_length_next = '0;
    end
    for (int k = 0; k < NUM_KEYS; k++) begin
      np[k]         = next_match(k, match_pos[k], char_in);
      pos_next[k]   = match_pos[k];
      found_next[k] = key_found[k];
      if (!key_found[k]) begin
        if (np[k] >= KEY_LEN[k]) begin
          found_next[k]       = 1'b1;
          pos_next[k]         = '0;
          capturing_next      = 1'b1;
          capture_key_next    = key_id_t'(k);
          capture_length_next = '0;
        end else begin
          pos_next[k] = np[k];
        end
      end
    end
    emit_eos = end_of_string && capturing_next && run_fits(capture_length_next, max_value_len);

    cmd.emit = emit_end || emit_eos;
    cmd.mark = end_of_string;
    cmd.key  = emit_end ? capture_key : capture_key_next;
    cmd.len  = emit_end ? capture_length : capture_length_next;
    cmd.bank = bank;
    cmd_push = accept && (cmd.emit || cmd.mark);

    buf_wr.en   = accept && capturing && valid_c && int'(capture_length) < MAX_VALUE_BUF;
    buf_wr.addr = {bank, capture_length[BUF_AW-1:0]};
    buf_wr.data = char_in;

    bank_busy_next = bank_busy;
    if (bank_rel.valid) bank_busy_next[bank_rel.bank] = 1'b0;
    if (accept && cmd.emit) bank_busy_next[bank] = 1'b1;

    if (end_of_string) begin
      for (int k = 0; k < NUM_KEYS; k++) pos_next[k] = '0;
      found_next          = '0;
      capturing_next      = 1'b0;
      capture_key_next    = '0;
      capture_length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value_len  <= MAX_LEN_RESET;
      for (int k = 0; k < NUM_KEYS; k++) match_pos[k] <= '0;
      key_found      <= '0;
      capturing      <= 1'b0;
      capture_key    <= '0;
      capture_length <= '0;
      bank           <= 1'b0;
      bank_busy      <= '0;
    end else begin
      if (cfg_we) max_value_len <= cfg_wdata;
      if (accept) begin
        for (int k = 0; k < NUM_KEYS; k++) match_pos[k] <= pos_next[k];
        key_found      <= found_next;
        capturing      <= capturing_next;
        capture_key    <= capture_key_next;
        capture_length <= capture_length_next;
        if (cmd.emit) bank <= !bank;
      end
      bank_busy <= bank_busy_next;
    end
  end

endmodule

/* hdl/uvx_back.sv */
// Back part: value buffer memory, emit sequencer and result queue.
module uvx_back (
  input  logic                clk,
  input  logic                rst,
  input  uvx_pkg::buf_wr_t    buf_wr,
  input  uvx_pkg::cmd_t       cmd_head,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output uvx_pkg::bank_rel_t  bank_rel,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          key_id,
  output logic [7:0]          value_char,
  output logic                last_of_value
);
  import uvx_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DATA = 2'd1;
  localparam logic [1:0] S_MARK = 2'd2;
  localparam int OAW = $clog2(OUTQ_DEPTH);

  typedef struct packed {
    key_id_t    key;
    logic [7:0] value;
    logic       last;
  } out_t;

  logic [7:0]      buf_mem [2*MAX_VALUE_BUF];
  logic [7:0]      mem_q;
  logic [1:0]      state;
  cmd_t            cur;
  logic [BUF_AW-1:0] idx;
  logic            rd_valid;
  logic            rd_mark;
  key_id_t         rd_key;
  logic            rd_last;
  out_t            outq [OUTQ_DEPTH];
  logic [OAW-1:0]  outq_wr;
  logic [OAW-1:0]  outq_rd;
  logic [OAW:0]    outq_cnt;
  logic            credit;
  logic            run_last;
  logic            issue;
  logic            do_pop;
  out_t            outq_in;

  always_comb begin
    credit   = (int'(outq_cnt) + int'(rd_valid)) < OUTQ_DEPTH;
    run_last = (LEN_W'(idx) + 1'b1) == cur.len;
    issue    = credit && (state == S_DATA || state == S_MARK);
    cmd_pop  = (state == S_IDLE) && !cmd_empty;
    bank_rel.valid = (state == S_DATA) && credit && run_last;
    bank_rel.bank  = cur.bank;
    do_pop   = pop && !empty;
    outq_in.key   = rd_mark ? KEY_MARK : rd_key;
    outq_in.value = rd_mark ? 8'h00 : to_lower(mem_q);
    outq_in.last  = rd_last;
    empty         = (outq_cnt == '0);
    key_id        = outq[outq_rd].key;
    value_char    = outq[outq_rd].value;
    last_of_value = outq[outq_rd].last;
  end

  always_ff @(posedge clk) begin
    if (buf_wr.en) buf_mem[buf_wr.addr] <= buf_wr.data;
    if (issue && state == S_DATA) mem_q <= buf_mem[{cur.bank, idx}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_valid <= 1'b0;
      outq_wr  <= '0;
      outq_rd  <= '0;
      outq_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            cur   <= cmd_head;
            idx   <= '0;
            state <= cmd_head.emit ? S_DATA : S_MARK;
          end
        end
        S_DATA: begin
          if (credit) begin
            if (run_last) state <= cur.mark ? S_MARK : S_IDLE;
            else idx <= idx + 1'b1;
          end
        end
        S_MARK: begin
          if (credit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      rd_valid <= issue;
      rd_mark  <= state == S_MARK;
      rd_key   <= cur.key;
      rd_last  <= (state == S_MARK) || run_last;
      if (rd_valid) begin
        outq[outq_wr] <= outq_in;
        outq_wr       <= (outq_wr == OAW'(OUTQ_DEPTH - 1)) ? '0 : outq_wr + 1'b1;
      end
      if (do_pop) outq_rd <= (outq_rd == OAW'(OUTQ_DEPTH - 1)) ? '0 : outq_rd + 1'b1;
      outq_cnt <= outq_cnt + (OAW + 1)'(rd_valid) - (OAW + 1)'(do_pop);
    end
  end

endmodule

/* hdl/url_tag_value_extractor.sv */
// Top level of the URL tag value extractor.
// One input item is one byte of a decoded query string. The front part matches the
// three utm keys and writes the value that follows into one of two 32-byte buffer
// banks; a two-entry command queue hands finished values and end markers to the
// back part, which reads the buffer memory through its one read port and delivers
// the result bytes while its result queue has room. The front stalls (full high)
// while the command queue is full or while the bank it would write still holds a
// value not yet read out.
module url_tag_value_extractor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                char_in,
  input  logic                      end_of_string,
  output logic                      empty,
  input  logic                      pop,
  output logic [1:0]                key_id,
  output logic [7:0]                value_char,
  output logic                      last_of_value,
  input  logic                      cfg_we,
  input  logic [uvx_pkg::CFG_W-1:0] cfg_wdata
);
  import uvx_pkg::*;

  cmd_t      cmd;
  cmd_t      cmd_head;
  logic      cmd_push;
  logic      cmd_full;
  logic      cmd_pop;
  logic      cmd_empty;
  buf_wr_t   buf_wr;
  bank_rel_t bank_rel;
  logic [1:0] bank_busy;

  uvx_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .char_in       (char_in),
    .end_of_string (end_of_string),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .cmd_push      (cmd_push),
    .cmd_full      (cmd_full),
    .buf_wr        (buf_wr),
    .bank_rel      (bank_rel),
    .bank_busy     (bank_busy)
  );

  uvx_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (cmd_push),
    .wr_cmd (cmd),
    .full   (cmd_full),
    .rd     (cmd_pop),
    .rd_cmd (cmd_head),
    .empty  (cmd_empty)
  );

  uvx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .buf_wr        (buf_wr),
    .cmd_head      (cmd_head),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .bank_rel      (bank_rel),
    .empty         (empty),
    .pop           (pop),
    .key_id        (key_id),
    .value_char    (value_char),
    .last_of_value (last_of_value)
  );

  a_cmd_push_space: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full) else $error("command pushed into a full queue");

  a_cmd_pop_data: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty) else $error("command popped from an empty queue");

  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    bank_rel.valid |-> bank_busy[bank_rel.bank]) else $error("release of an idle bank");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && key_id == KEY_MARK) |-> (value_char == 8'h00 && last_of_value))
    else $error("malformed end marker item");

endmodule
